[hdl/igd_plus_front_metric_macros.svh]
// Assertion macros shared by the IGD+ front metric block.
`ifndef IGD_PLUS_FRONT_METRIC_MACROS_SVH
`define IGD_PLUS_FRONT_METRIC_MACROS_SVH
`define IGDP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define IGDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hdl/igdp_pkg.sv]
// ----------------------------------------------------------------------------
// igdp_pkg
// Types and constants of the IGD+ front metric block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package igdp_pkg;
    localparam int FRONT_DEPTH          = 256;
    localparam int OBJECTIVES           = 4;
    localparam int MAX_REFERENCE_POINTS = 65535;
    localparam int OBJ_USED  = (OBJECTIVES < 4) ? OBJECTIVES : 4;
    localparam int ADDR_W    = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;
    localparam int COUNT_W   = $clog2(FRONT_DEPTH + 1);
    localparam int ENTRY_W   = 24 * OBJ_USED;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [0:0] OP_FRONT     = 1'b0;
    localparam logic [0:0] OP_REFERENCE = 1'b1;

    localparam logic [0:0] REG_SENSE_MASK = 1'b0;
    localparam logic [0:0] REG_DIVISOR    = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_ZERO_DIV = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    typedef struct packed {
        logic        operation;
        logic signed [23:0] objective_0;
        logic signed [23:0] objective_1;
        logic signed [23:0] objective_2;
        logic signed [23:0] objective_3;
        logic        final_reference;
    } in_word_t;

    typedef struct packed {
        logic [25:0] mean_distance;
        logic [16:0] normalized_metric;
        logic [1:0]  status;
    } out_word_t;

    typedef struct packed {
        logic [0:0]  index;
        logic [25:0] data;
    } cfg_word_t;

    // Reference job handed from the front part to the back part.
    typedef struct packed {
        logic signed [23:0] obj_0;
        logic signed [23:0] obj_1;
        logic signed [23:0] obj_2;
        logic signed [23:0] obj_3;
        logic               final_reference;
        logic [COUNT_W-1:0] front_count;
        logic               overflowed;
    } job_t;
endpackage
`default_nettype wire

[hdl/igd_plus_front_metric.sv]
// ----------------------------------------------------------------------------
// igd_plus_front_metric
// IGD+ metric of a four-objective front in Q12.12 fixed point.
//
// Channel   Handshake              Word
// in        start / busy           in_word  (in_word_t)
// cfg       cfg_valid / cfg_ready  cfg_word (cfg_word_t)
// out       done strobe            result   (out_word_t)
//
// A front word is written to the store as it is accepted. For a reference
// word, the stored points are read one per cycle, then the square root is
// taken. The final reference adds two divisions.
// A two-entry queue lets front words load while a scan runs; busy is high
// while that queue is full, and after a final reference until its result is
// out. Reset is asynchronous; the front store needs none.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module igd_plus_front_metric (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire igdp_pkg::in_word_t  in_word,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire igdp_pkg::cfg_word_t cfg_word,
    output logic                     done,
    output igdp_pkg::out_word_t      result
);
    logic [3:0]  sense_reg;
    logic [25:0] divisor_reg;
    logic accept, stall, wr_en, job_valid, job_pop, back_busy;
    logic [igdp_pkg::ADDR_W-1:0]  wr_addr, rd_addr;
    logic [igdp_pkg::ENTRY_W-1:0] wr_data, rd_data;
    igdp_pkg::job_t job;

    assign busy      = stall;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sense_reg   <= '0;
            divisor_reg <= 26'd4096;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_word.index)
                igdp_pkg::REG_SENSE_MASK: sense_reg   <= cfg_word.data[3:0];
                igdp_pkg::REG_DIVISOR:    divisor_reg <= cfg_word.data;
                default: ;
            endcase
        end
    end

    igdp_front u_front (
        .clk, .rst_n, .accept, .word(in_word), .back_busy,
        .stall, .wr_en, .wr_addr, .wr_data, .job_valid, .job, .job_pop
    );

    igdp_ram #(.WIDTH(igdp_pkg::ENTRY_W), .DEPTH(igdp_pkg::FRONT_DEPTH)) u_store (
        .clk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
    );

    igdp_back u_back (
        .clk, .rst_n, .sense_mask(sense_reg), .divisor(divisor_reg), .job_valid, .job,
        .job_pop, .rd_addr, .rd_data, .done, .result, .busy(back_busy)
    );
endmodule
`default_nettype wire

[hdl/igdp_ram.sv]
// ----------------------------------------------------------------------------
// igdp_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module igdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

[hdl/igdp_front.sv]
// ----------------------------------------------------------------------------
// igdp_front
// Accepts words, stores front points and queues reference jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "igd_plus_front_metric_macros.svh"
module igdp_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire igdp_pkg::in_word_t           word,
    input  wire logic                         back_busy,
    output logic                              stall,
    output logic                              wr_en,
    output logic [igdp_pkg::ADDR_W-1:0]       wr_addr,
    output logic [igdp_pkg::ENTRY_W-1:0]      wr_data,
    output logic                              job_valid,
    output igdp_pkg::job_t                    job,
    input  wire logic                         job_pop
);
    logic [igdp_pkg::COUNT_W-1:0] count_reg, count_next;
    logic overflow_reg, overflow_next;
    logic restart_reg, restart_next;
    igdp_pkg::job_t q_reg [igdp_pkg::QUEUE_DEPTH];
    logic [1:0] q_cnt_reg, q_cnt_next;
    logic [0:0] q_wp_reg, q_rp_reg;
    logic is_front, push;
    logic queue_full;
    logic [igdp_pkg::COUNT_W-1:0] base_count;
    logic base_ovf;
    logic [4*24-1:0] objs;

    assign is_front   = accept && (word.operation == igdp_pkg::OP_FRONT);
    assign push       = accept && (word.operation == igdp_pkg::OP_REFERENCE);
    assign base_count = restart_reg ? '0 : count_reg;
    assign base_ovf   = restart_reg ? 1'b0 : overflow_reg;
    assign objs = {word.objective_3, word.objective_2, word.objective_1, word.objective_0};

    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        restart_next  = restart_reg;
        wr_en         = 1'b0;
        wr_addr       = base_count[igdp_pkg::ADDR_W-1:0];
        wr_data       = objs[igdp_pkg::ENTRY_W-1:0];
        if (is_front)
        begin
            restart_next  = 1'b0;
            count_next    = base_count;
            overflow_next = base_ovf;
            if (base_count < igdp_pkg::COUNT_W'(igdp_pkg::FRONT_DEPTH))
            begin
                wr_en      = 1'b1;
                count_next = base_count + 1'b1;
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
        // The next front word starts a new front once a final reference is queued.
        if (push && word.final_reference)
        begin
            restart_next = 1'b1;
        end
    end

    assign q_cnt_next = q_cnt_reg + {1'b0, push} - {1'b0, job_pop};
    assign queue_full = (q_cnt_reg == 2'(igdp_pkg::QUEUE_DEPTH));
    // A restarting front would overwrite points that a pending scan still reads.
    assign stall      = queue_full || (restart_reg && (job_valid || back_busy));
    assign job_valid  = (q_cnt_reg != 2'd0);
    assign job        = q_reg[q_rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[q_wp_reg] <= '{obj_0: word.objective_0, obj_1: word.objective_1,
                                 obj_2: word.objective_2, obj_3: word.objective_3,
                                 final_reference: word.final_reference,
                                 front_count: count_reg, overflowed: overflow_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            restart_reg  <= 1'b1;
            q_cnt_reg    <= '0;
            q_wp_reg     <= '0;
            q_rp_reg     <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            restart_reg  <= restart_next;
            q_cnt_reg    <= q_cnt_next;
            if (push)
            begin
                q_wp_reg <= q_wp_reg + 1'b1;
            end
            if (job_pop)
            begin
                q_rp_reg <= q_rp_reg + 1'b1;
            end
        end
    end

    `IGDP_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, !queue_full, "push into full queue")
    `IGDP_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, job_pop, job_valid, "pop from empty queue")
    `IGDP_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1,
        count_reg <= igdp_pkg::COUNT_W'(igdp_pkg::FRONT_DEPTH), "front count out of range")
endmodule
`default_nettype wire

[hdl/igdp_back.sv]
// ----------------------------------------------------------------------------
// igdp_back
// Scans the front for each reference job, accumulates and emits the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "igd_plus_front_metric_macros.svh"
module igdp_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [3:0]                   sense_mask,
    input  wire logic [25:0]                  divisor,
    input  wire logic                         job_valid,
    input  wire igdp_pkg::job_t               job,
    output logic                              job_pop,
    output logic [igdp_pkg::ADDR_W-1:0]       rd_addr,
    input  wire logic [igdp_pkg::ENTRY_W-1:0] rd_data,
    output logic                              done,
    output igdp_pkg::out_word_t               result,
    output logic                              busy
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_SCAN = 7'b0000010, S_ROOT = 7'b0000100,
        S_ACC  = 7'b0001000, S_DIV1 = 7'b0010000, S_DIV2 = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    igdp_pkg::job_t job_reg;
    logic [igdp_pkg::COUNT_W-1:0] issue_reg, recv_reg;
    logic rd_pend_reg;
    logic [49:0] sq_reg [4];
    logic sq_vld_reg;
    logic [49:0] sum_reg;
    logic sum_vld_reg;
    logic [49:0] best_sq_reg;
    logic best_any_reg;
    logic [49:0] rad_reg;
    logic [25:0] sqrem_reg;
    logic [25:0] root_reg;
    logic [4:0]  rstep_reg;
    logic [41:0] dsum_reg;
    logic [15:0] rcnt_reg;
    logic [57:0] num_reg;
    logic [57:0] rem_reg;
    logic [5:0]  dstep_reg;
    logic [41:0] quot_reg;
    logic [25:0] mean_reg;
    logic [41:0] dvs_reg;
    logic [1:0]  status_reg;
    logic [23:0] ref_obj [4];
    logic [23:0] pt_obj [4];
    logic [49:0] sq_sum;
    logic [28:0] trial;
    logic [58:0] dtrial;

    assign ref_obj[0] = job_reg.obj_0;
    assign ref_obj[1] = job_reg.obj_1;
    assign ref_obj[2] = job_reg.obj_2;
    assign ref_obj[3] = job_reg.obj_3;

    // Worse-side differences and squares, one stored point per cycle.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (i < igdp_pkg::OBJ_USED)
            begin
                pt_obj[i] = rd_data[24*(i%igdp_pkg::OBJ_USED) +: 24];
            end
            else
            begin
                pt_obj[i] = ref_obj[i];
            end
        end
    end

    assign sq_sum = sq_reg[0] + sq_reg[1] + sq_reg[2] + sq_reg[3];
    assign rd_addr = issue_reg[igdp_pkg::ADDR_W-1:0];
    assign job_pop = (state_reg == S_IDLE) && job_valid;
    assign busy    = (state_reg != S_IDLE);
    assign trial   = {1'b0, sqrem_reg, rad_reg[49:48]} - {1'b0, root_reg, 2'b01};
    assign dtrial  = {rem_reg, num_reg[57]} - {17'd0, dvs_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (job_valid) state_next = S_SCAN;
            S_SCAN: if (recv_reg == job_reg.front_count && !rd_pend_reg && !sq_vld_reg
                        && !sum_vld_reg) state_next = S_ROOT;
            S_ROOT: if (rstep_reg == 5'd0) state_next = S_ACC;
            S_ACC:  state_next = job_reg.final_reference ? S_DIV1 : S_IDLE;
            S_DIV1: if (dstep_reg == 6'd0) state_next = S_DIV2;
            S_DIV2: if (dstep_reg == 6'd0) state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job;
        end
        for (int i = 0; i < 4; i++)
        begin
            if (sense_mask[i])
            begin
                sq_reg[i] <= ($signed(ref_obj[i]) > $signed(pt_obj[i]))
                    ? 50'((25'($signed(ref_obj[i])) - 25'($signed(pt_obj[i])))
                          * (25'($signed(ref_obj[i])) - 25'($signed(pt_obj[i]))))
                    : '0;
            end
            else
            begin
                sq_reg[i] <= ($signed(pt_obj[i]) > $signed(ref_obj[i]))
                    ? 50'((25'($signed(pt_obj[i])) - 25'($signed(ref_obj[i])))
                          * (25'($signed(pt_obj[i])) - 25'($signed(ref_obj[i]))))
                    : '0;
            end
        end
        sum_reg <= sq_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            issue_reg    <= '0;
            recv_reg     <= '0;
            rd_pend_reg  <= 1'b0;
            sq_vld_reg   <= 1'b0;
            sum_vld_reg  <= 1'b0;
            best_sq_reg  <= '0;
            best_any_reg <= 1'b0;
            rad_reg      <= '0;
            sqrem_reg    <= '0;
            root_reg     <= '0;
            rstep_reg    <= '0;
            dsum_reg     <= '0;
            rcnt_reg     <= '0;
            num_reg      <= '0;
            rem_reg      <= '0;
            dstep_reg    <= '0;
            quot_reg     <= '0;
            mean_reg     <= '0;
            dvs_reg      <= '0;
            status_reg   <= igdp_pkg::STATUS_OK;
            done         <= 1'b0;
            result       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    issue_reg    <= '0;
                    recv_reg     <= '0;
                    rd_pend_reg  <= 1'b0;
                    sq_vld_reg   <= 1'b0;
                    sum_vld_reg  <= 1'b0;
                    best_any_reg <= 1'b0;
                    best_sq_reg  <= '0;
                end
                S_SCAN:
                begin
                    rd_pend_reg <= (issue_reg != job_reg.front_count);
                    if (issue_reg != job_reg.front_count)
                    begin
                        issue_reg <= issue_reg + 1'b1;
                    end
                    sq_vld_reg  <= rd_pend_reg;
                    sum_vld_reg <= sq_vld_reg;
                    if (sum_vld_reg)
                    begin
                        recv_reg <= recv_reg + 1'b1;
                        if (!best_any_reg || sum_reg < best_sq_reg)
                        begin
                            best_sq_reg <= sum_reg;
                        end
                        best_any_reg <= 1'b1;
                    end
                    rad_reg   <= best_sq_reg;
                    sqrem_reg <= '0;
                    root_reg  <= '0;
                    rstep_reg <= 5'd24;
                end
                S_ROOT:
                begin
                    // One result bit per cycle, taking the radicand two bits at a time.
                    if (!trial[28])
                    begin
                        sqrem_reg <= trial[25:0];
                        root_reg  <= {root_reg[24:0], 1'b1};
                    end
                    else
                    begin
                        sqrem_reg <= {sqrem_reg[23:0], rad_reg[49:48]};
                        root_reg  <= {root_reg[24:0], 1'b0};
                    end
                    rad_reg   <= {rad_reg[47:0], 2'b00};
                    rstep_reg <= rstep_reg - 1'b1;
                end
                S_ACC:
                begin
                    if (rcnt_reg < 16'(igdp_pkg::MAX_REFERENCE_POINTS))
                    begin
                        dsum_reg <= dsum_reg + 42'(root_reg);
                        rcnt_reg <= rcnt_reg + 1'b1;
                    end
                    num_reg   <= {dsum_reg
                        + ((rcnt_reg < 16'(igdp_pkg::MAX_REFERENCE_POINTS))
                           ? 42'(root_reg) : 42'd0), 16'd0};
                    dvs_reg   <= 42'(rcnt_reg
                        + ((rcnt_reg < 16'(igdp_pkg::MAX_REFERENCE_POINTS)) ? 16'd1 : 16'd0));
                    rem_reg   <= '0;
                    dstep_reg <= 6'd42;
                    quot_reg  <= '0;
                end
                S_DIV1:
                begin
                    // Restoring divide of the distance sum by the reference count.
                    if (dstep_reg != 6'd0)
                    begin
                        if (!dtrial[58])
                        begin
                            rem_reg <= dtrial[57:0];
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[56:0], num_reg[57]};
                        end
                        quot_reg  <= {quot_reg[40:0], !dtrial[58]};
                        num_reg   <= {num_reg[56:0], 1'b0};
                        dstep_reg <= dstep_reg - 1'b1;
                    end
                    else
                    begin
                        mean_reg  <= (dvs_reg == '0) ? 26'd0 : quot_reg[25:0];
                        num_reg   <= {(dvs_reg == '0) ? 26'd0 : quot_reg[25:0], 16'd0, 16'd0};
                        dvs_reg   <= 42'(divisor);
                        rem_reg   <= '0;
                        quot_reg  <= '0;
                        dstep_reg <= 6'd42;
                    end
                end
                S_DIV2:
                begin
                    if (dstep_reg != 6'd0)
                    begin
                        if (!dtrial[58] && dvs_reg != '0)
                        begin
                            rem_reg <= dtrial[57:0];
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[56:0], num_reg[57]};
                        end
                        quot_reg  <= {quot_reg[40:0], !dtrial[58] && dvs_reg != '0};
                        num_reg   <= {num_reg[56:0], 1'b0};
                        dstep_reg <= dstep_reg - 1'b1;
                    end
                end
                S_OUT:
                begin
                    done     <= 1'b1;
                    dsum_reg <= '0;
                    rcnt_reg <= '0;
                    if (job_reg.front_count == '0)
                    begin
                        result <= '{mean_distance: 26'd0, normalized_metric: 17'd0,
                                    status: igdp_pkg::STATUS_EMPTY};
                    end
                    else if (dvs_reg == '0)
                    begin
                        result <= '{mean_distance: mean_reg, normalized_metric: 17'd0,
                                    status: igdp_pkg::STATUS_ZERO_DIV};
                    end
                    else
                    begin
                        result <= '{mean_distance: mean_reg,
                                    normalized_metric: (quot_reg > 42'd65536)
                                        ? 17'd65536 : quot_reg[16:0],
                                    status: job_reg.overflowed
                                        ? igdp_pkg::STATUS_OVERFLOW : igdp_pkg::STATUS_OK};
                    end
                end
                default: ;
            endcase
        end
    end

    `IGDP_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "result strobe longer than one cycle")
    `IGDP_ASSERT_IMPL(a_recv_le_issue, clk, rst_n, 1'b1, recv_reg <= issue_reg,
        "more points received than read")
    `IGDP_ASSERT_NEXT(a_out_done, clk, rst_n, state_reg == S_OUT, done,
        "result state without strobe")
endmodule
`default_nettype wire
